// ===== sv/tvpt_pkg.sv =====
// Package with shared widths, descriptor layout constants and fixed-point helpers.
`timescale 1ns / 1ps
package tvpt_pkg;
	localparam int TableDepth = 64;
	localparam int WordWidth  = 32;
	localparam int FracBits   = 16;
	localparam int IdxWidth   = 6;
	localparam int CapBase    = 30;
	localparam int CapStride  = 8;

	typedef logic signed [WordWidth-1:0] word_t;
	typedef logic [IdxWidth-1:0] idx_t;

	localparam logic OpWrite = 1'b0;
	localparam logic OpTest  = 1'b1;

	localparam word_t WordMax = {1'b0, {(WordWidth-1){1'b1}}};
	localparam word_t WordMin = {1'b1, {(WordWidth-1){1'b0}}};

	// Saturate a value one bit wider than a word.
	function automatic word_t sat1(input logic signed [WordWidth:0] x);
		word_t r;
		if (x > $signed({{2{1'b0}}, {(WordWidth-1){1'b1}}})) r = WordMax;
		else if (x < $signed({{2{1'b1}}, {(WordWidth-1){1'b0}}})) r = WordMin;
		else r = x[WordWidth-1:0];
		return r;
	endfunction

	// Saturate a value two bits wider than a word.
	function automatic word_t sat2(input logic signed [WordWidth+1:0] x);
		word_t r;
		if (x > $signed({{3{1'b0}}, {(WordWidth-1){1'b1}}})) r = WordMax;
		else if (x < $signed({{3{1'b1}}, {(WordWidth-1){1'b0}}})) r = WordMin;
		else r = x[WordWidth-1:0];
		return r;
	endfunction
endpackage

// ===== sv/tvpt_if.sv =====
// Valid/ready channel interfaces for the input and result words.
`timescale 1ns / 1ps
interface tvpt_in_if;
	import tvpt_pkg::*;
	logic  valid;
	logic  ready;
	logic  op;
	idx_t  coef_index;
	word_t coef_value;
	word_t point_x;
	word_t point_y;
	word_t point_z;
	modport source (output valid, op, coef_index, coef_value, point_x, point_y, point_z,
		input ready);
	modport sink (input valid, op, coef_index, coef_value, point_x, point_y, point_z,
		output ready);
endinterface

interface tvpt_out_if;
	logic valid;
	logic ready;
	logic inside_res;
	modport source (output valid, inside_res, input ready);
	modport sink (input valid, inside_res, output ready);
endinterface

// ===== sv/triangle_voxel_point_test.sv =====
// Top level: descriptor store, sequencer and shared multiplier for the point test.
`timescale 1ns / 1ps
// A write word stores one descriptor word. A test word takes its point through one
// registered multiplier shared by all plane and capsule products, under a sequencer that
// reads one descriptor word at a time from the internal memory. A plane takes six reads,
// each through S_RD, S_RDW and S_LATCH, three products, each through S_MUL, S_MULW and
// S_ACC, and one decision. A capsule whose radius is negative counts as outside and skips
// its residual vector. The test stops at the first region that settles the answer, and
// the result word is then held until ready. The block takes no new word while a test
// runs or its result waits.
module triangle_voxel_point_test (
	input logic clk,
	input logic arst_n,
	tvpt_in_if.sink  in_ch,
	tvpt_out_if.source out_ch
);
	import tvpt_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_RD, S_RDW, S_LATCH, S_MUL, S_MULW, S_ACC, S_PDONE,
		S_CRAD, S_CRADW, S_CR2, S_CLEN, S_CLENW, S_CSEL, S_QMUL, S_QMULW, S_QSET,
		S_SQ, S_SQW, S_SQACC, S_CDONE, S_OUT
	} state_t;

	state_t st_q;
	word_t mem [TableDepth];
	word_t rdata_q;
	idx_t raddr;
	word_t px_q, py_q, pz_q;
	logic [1:0] k_q; // element within a triple
	logic [2:0] blk_q; // plane 0..4 or capsule 0..2
	logic caps_q;
	logic [1:0] ph_q; // read phase: 0 point/center, 1 normal/dir
	word_t c_q [3];
	word_t w_q [3];
	word_t d_q [3];
	word_t q_q [3];
	logic signed [WordWidth+1:0] acc_q;
	word_t d0_q, s0_q, r2_q, len_q;
	logic side_q;
	logic inside_q;
	word_t ma, mb, mp;

	tvpt_fmul u_mul (.clk(clk), .a(ma), .b(mb), .p_q(mp));

	function automatic word_t pick(input word_t x, y, z, input logic [1:0] i);
		word_t r;
		case (i)
			2'd0: r = x;
			2'd1: r = y;
			default: r = z;
		endcase
		return r;
	endfunction

	// Descriptor word address for the current step.
	always_comb begin
		if (!caps_q)
			raddr = IdxWidth'(6 * int'(blk_q) + 3 * int'(ph_q) + int'(k_q));
		else if (st_q == S_CRAD || st_q == S_CRADW || st_q == S_CR2)
			raddr = IdxWidth'(CapBase + CapStride * int'(blk_q) + 7);
		else if (st_q == S_CLEN || st_q == S_CLENW)
			raddr = IdxWidth'(CapBase + CapStride * int'(blk_q) + 6);
		else
			raddr = IdxWidth'(CapBase + CapStride * int'(blk_q) + 3 * int'(ph_q) + int'(k_q));
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready && in_ch.op == OpWrite)
			mem[in_ch.coef_index] <= in_ch.coef_value;
		rdata_q <= mem[raddr];
	end

	word_t pv;
	word_t wd;
	word_t nab;
	always_comb begin
		pv = pick(px_q, py_q, pz_q, k_q);
		wd = sat1($signed({pv[WordWidth-1], pv}) - $signed({c_q[k_q][WordWidth-1], c_q[k_q]}));
		nab = sat1(-$signed({d0_q[WordWidth-1], d0_q}));
		ma = d_q[k_q];
		mb = w_q[k_q];
		unique case (st_q)
			S_CRAD, S_CRADW, S_CR2: begin ma = rdata_q; mb = rdata_q; end
			S_QMUL, S_QMULW, S_QSET: begin
				ma = side_q ? d0_q : s0_q;
				mb = d_q[k_q];
			end
			S_SQ, S_SQW, S_SQACC: begin ma = q_q[k_q]; mb = q_q[k_q]; end
			default: ;
		endcase
	end

	assign in_ch.ready = (st_q == S_IDLE);
	assign out_ch.valid = (st_q == S_OUT);
	assign out_ch.inside_res = inside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			k_q <= '0;
			blk_q <= '0;
			caps_q <= 1'b0;
			ph_q <= '0;
			inside_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (in_ch.valid && in_ch.op == OpTest) begin
						px_q <= in_ch.point_x;
						py_q <= in_ch.point_y;
						pz_q <= in_ch.point_z;
						blk_q <= '0;
						caps_q <= 1'b0;
						ph_q <= '0;
						k_q <= '0;
						st_q <= S_RD;
					end
				end
				// Read point/center then normal/dir triples.
				S_RD: st_q <= S_RDW;
				S_RDW: st_q <= S_LATCH;
				S_LATCH: begin
					if (ph_q == 2'd0) c_q[k_q] <= rdata_q;
					else d_q[k_q] <= rdata_q;
					if (k_q == 2'd2) begin
						k_q <= '0;
						if (ph_q == 2'd0) begin
							ph_q <= 2'd1;
							st_q <= S_RD;
						end else begin
							st_q <= S_MUL;
							acc_q <= '0;
						end
					end else begin
						k_q <= k_q + 2'd1;
						st_q <= S_RD;
					end
				end
				S_MUL: begin
					w_q[k_q] <= wd;
					st_q <= S_MULW;
				end
				S_MULW: st_q <= S_ACC;
				S_ACC: begin
					acc_q <= acc_q + (WordWidth+2)'(mp);
					if (k_q == 2'd2) begin
						k_q <= '0;
						st_q <= caps_q ? S_CRAD : S_PDONE;
					end else begin
						k_q <= k_q + 2'd1;
						st_q <= S_MUL;
					end
				end
				S_PDONE: begin
					ph_q <= '0;
					if (sat2(acc_q) > 0) begin
						caps_q <= 1'b1;
						blk_q <= '0;
						st_q <= S_RD;
					end else if (blk_q == 3'd4) begin
						inside_q <= 1'b1;
						st_q <= S_OUT;
					end else begin
						blk_q <= blk_q + 3'd1;
						st_q <= S_RD;
					end
				end
				// Capsule: radius squared, half length, then the residual vector.
				S_CRAD: begin
					d0_q <= sat2(acc_q);
					st_q <= S_CRADW;
				end
				S_CRADW: st_q <= S_CR2;
				S_CR2: st_q <= S_CLEN;
				S_CLEN: begin
					r2_q <= mp;
					side_q <= rdata_q[WordWidth-1];
					st_q <= S_CLENW;
				end
				S_CLENW: begin
					len_q <= rdata_q;
					st_q <= S_CSEL;
				end
				S_CSEL: begin
					s0_q <= len_q >>> 1;
					if (side_q) begin
						inside_q <= 1'b0;
						st_q <= S_CDONE;
						acc_q <= '0;
					end else begin
						side_q <= ((d0_q[WordWidth-1] ? nab : d0_q) <= (len_q >>> 1));
						k_q <= '0;
						st_q <= S_QMUL;
					end
				end
				S_QMUL: st_q <= S_QMULW;
				S_QMULW: st_q <= S_QSET;
				S_QSET: begin
					if (side_q)
						q_q[k_q] <= sat1($signed({w_q[k_q][WordWidth-1], w_q[k_q]})
							- $signed({mp[WordWidth-1], mp}));
					else if (d0_q > 0)
						q_q[k_q] <= sat1($signed({pv[WordWidth-1], pv}) - $signed({
							sat1($signed({c_q[k_q][WordWidth-1], c_q[k_q]})
							+ $signed({mp[WordWidth-1], mp}))}));
					else
						q_q[k_q] <= sat1($signed({pv[WordWidth-1], pv}) - $signed({
							sat1($signed({c_q[k_q][WordWidth-1], c_q[k_q]})
							- $signed({mp[WordWidth-1], mp}))}));
					if (k_q == 2'd2) begin
						k_q <= '0;
						acc_q <= '0;
						st_q <= S_SQ;
					end else begin
						k_q <= k_q + 2'd1;
						st_q <= S_QMUL;
					end
				end
				S_SQ: st_q <= S_SQW;
				S_SQW: st_q <= S_SQACC;
				S_SQACC: begin
					acc_q <= acc_q + (WordWidth+2)'(mp);
					if (k_q == 2'd2) begin
						k_q <= '0;
						inside_q <= (sat2(acc_q + (WordWidth+2)'(mp)) <= r2_q);
						st_q <= S_CDONE;
					end else begin
						k_q <= k_q + 2'd1;
						st_q <= S_SQ;
					end
				end
				S_CDONE: begin
					ph_q <= '0;
					if (inside_q || blk_q == 3'd2) st_q <= S_OUT;
					else begin
						blk_q <= blk_q + 3'd1;
						st_q <= S_RD;
					end
				end
				S_OUT: if (out_ch.ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.inside_res))
		else $error("result word changed while stalled");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("input ready while result pending");
	a_blk: assert property (@(posedge clk) disable iff (!arst_n)
		caps_q |-> blk_q <= 3'd2)
		else $error("capsule index out of range");
`endif
endmodule

// ===== sv/tvpt_fmul.sv =====
// Registered fixed-point multiplier: floor of product over 2^FracBits, saturated.
`timescale 1ns / 1ps
module tvpt_fmul (
	input  logic              clk,
	input  tvpt_pkg::word_t   a,
	input  tvpt_pkg::word_t   b,
	output tvpt_pkg::word_t   p_q
);
	import tvpt_pkg::*;
	logic signed [2*WordWidth-1:0] prod;
	logic signed [2*WordWidth-FracBits-1:0] sh;
	word_t res;

	// Arithmetic shift gives the floor; then clamp to the word range.
	always_comb begin
		prod = a * b;
		sh = prod[2*WordWidth-1:FracBits];
		if (sh > $signed({{(WordWidth-FracBits+1){1'b0}}, {(WordWidth-1){1'b1}}}))
			res = WordMax;
		else if (sh < $signed({{(WordWidth-FracBits+1){1'b1}}, {(WordWidth-1){1'b0}}}))
			res = WordMin;
		else
			res = sh[WordWidth-1:0];
	end

	always_ff @(posedge clk) begin
		p_q <= res;
	end
endmodule
